// ===== design/eba_pkg.sv =====
`timescale 1ns / 1ps

package eba_pkg;

  // Operation codes
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBC  = 5'd3;
  localparam logic [4:0] OP_AND  = 5'd4;
  localparam logic [4:0] OP_XOR  = 5'd5;
  localparam logic [4:0] OP_OR   = 5'd6;
  localparam logic [4:0] OP_CP   = 5'd7;
  localparam logic [4:0] OP_RLC  = 5'd8;
  localparam logic [4:0] OP_RRC  = 5'd9;
  localparam logic [4:0] OP_RL   = 5'd10;
  localparam logic [4:0] OP_RR   = 5'd11;
  localparam logic [4:0] OP_SLA  = 5'd12;
  localparam logic [4:0] OP_SRA  = 5'd13;
  localparam logic [4:0] OP_SWAP = 5'd14;
  localparam logic [4:0] OP_SRL  = 5'd15;
  localparam logic [4:0] OP_RLCA = 5'd16;
  localparam logic [4:0] OP_RRCA = 5'd17;
  localparam logic [4:0] OP_RLA  = 5'd18;
  localparam logic [4:0] OP_RRA  = 5'd19;
  localparam logic [4:0] OP_DAA  = 5'd20;
  localparam logic [4:0] OP_CPL  = 5'd21;
  localparam logic [4:0] OP_SCF  = 5'd22;
  localparam logic [4:0] OP_CCF  = 5'd23;
  localparam logic [4:0] OP_ADDW = 5'd24;

  // Shift kinds, taken from the low three bits of a shift or rotate code
  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // DAA constants
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_HI_CORR = 8'h60;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'h9;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  accumulator;
    logic [7:0]  operand;
    logic [3:0]  flags_in;
    logic [15:0] word_in;
  } eba_item_t;

  typedef struct packed {
    logic [7:0]  byte_result;
    logic [15:0] word_result;
    logic [3:0]  flags_out;
  } eba_result_t;

endpackage

// ===== design/eba_core.sv =====
`timescale 1ns / 1ps

module eba_core import eba_pkg::*; (
  input  eba_item_t   item,
  output eba_result_t result
);

  // Returns {carry, result}
  function automatic logic [8:0] shift_calc(logic [2:0] kind, logic [7:0] x, logic cin);
    logic [8:0] r;
    case (kind)
      SH_RLC:  r = {x[7], x[6:0], x[7]};
      SH_RRC:  r = {x[0], x[0], x[7:1]};
      SH_RL:   r = {x[7], x[6:0], cin};
      SH_RR:   r = {x[0], cin, x[7:1]};
      SH_SLA:  r = {x[7], x[6:0], 1'b0};
      SH_SRA:  r = {x[0], x[7], x[7:1]};
      SH_SWAP: r = {1'b0, x[3:0], x[7:4]};
      default: r = {x[0], 1'b0, x[7:1]};
    endcase
    return r;
  endfunction

  logic [7:0] a;
  logic [7:0] v;
  logic       fz, fn, fh, fc;
  logic       cin_arith;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [8:0] sh_val;
  logic [8:0] ash_val;
  logic [7:0] daa_corr;
  logic       daa_c;
  logic [7:0] daa_val;
  logic [15:0] word_sum;
  logic [8:0] wlo9;
  logic [4:0] wlo5;

  assign a  = item.accumulator;
  assign v  = item.operand;
  assign fz = item.flags_in[FLAG_Z];
  assign fn = item.flags_in[FLAG_N];
  assign fh = item.flags_in[FLAG_H];
  assign fc = item.flags_in[FLAG_C];

  // Carry-in only for ADC and SBC
  assign cin_arith = ((item.operation == OP_ADC) || (item.operation == OP_SBC)) & fc;

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin_arith};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin_arith};
  assign diff9  = {1'b0, a} - {1'b0, v} - {8'd0, cin_arith};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin_arith};

  assign sh_val  = shift_calc(item.operation[2:0], v, fc);
  assign ash_val = shift_calc(item.operation[2:0], a, fc);

  always_comb begin
    daa_corr = 8'd0;
    daa_c    = fc;
    if (fh || (!fn && (a[3:0] > DAA_LO_LIM))) begin
      daa_corr = daa_corr | DAA_LO_CORR;
    end
    if (fc || (!fn && (a > DAA_HI_LIM))) begin
      daa_corr = daa_corr | DAA_HI_CORR;
      daa_c    = 1'b1;
    end
  end

  assign daa_val = fn ? (a - daa_corr) : (a + daa_corr);

  assign word_sum = item.word_in + {{8{v[7]}}, v};
  assign wlo9     = {1'b0, item.word_in[7:0]} + {1'b0, v};
  assign wlo5     = {1'b0, item.word_in[3:0]} + {1'b0, v[3:0]};

  always_comb begin
    result.byte_result = a;
    result.word_result = 16'd0;
    result.flags_out   = item.flags_in;
    unique case (item.operation) inside
      OP_ADD, OP_ADC: begin
        result.byte_result = sum9[7:0];
        result.flags_out   = {sum9[7:0] == 8'd0, 1'b0, hsum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        result.byte_result = diff9[7:0];
        result.flags_out   = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
      end
      OP_CP: begin
        // compare: flags only, accumulator unchanged
        result.flags_out = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
      end
      OP_AND: begin
        result.byte_result = a & v;
        result.flags_out   = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        result.byte_result = a ^ v;
        result.flags_out   = {(a ^ v) == 8'd0, 3'b000};
      end
      OP_OR: begin
        result.byte_result = a | v;
        result.flags_out   = {(a | v) == 8'd0, 3'b000};
      end
      [OP_RLC:OP_SRL]: begin
        result.byte_result = sh_val[7:0];
        result.flags_out   = {sh_val[7:0] == 8'd0, 2'b00, sh_val[8]};
      end
      [OP_RLCA:OP_RRA]: begin
        // accumulator rotates always clear Z
        result.byte_result = ash_val[7:0];
        result.flags_out   = {3'b000, ash_val[8]};
      end
      OP_DAA: begin
        result.byte_result = daa_val;
        result.flags_out   = {daa_val == 8'd0, fn, 1'b0, daa_c};
      end
      OP_CPL: begin
        result.byte_result = ~a;
        result.flags_out   = {fz, 1'b1, 1'b1, fc};
      end
      OP_SCF: begin
        result.flags_out = {fz, 2'b00, 1'b1};
      end
      OP_CCF: begin
        result.flags_out = {fz, 2'b00, ~fc};
      end
      OP_ADDW: begin
        result.word_result = word_sum;
        result.flags_out   = {2'b00, wlo5[4], wlo9[8]};
      end
      default: begin
        // unused codes pass the accumulator and flags through
      end
    endcase
  end

endmodule

// ===== design/eight_bit_alu_with_flags.sv =====
`timescale 1ns / 1ps
// Each input beat passes an input register and then a result register to become a result beat.
// Throughput: one beat per cycle unless the output stalls; the ALU is one pass of 8- and
// 16-bit logic between the two registers, and the result register frees as its beat is taken.
// Reset: synchronous, active high; clears both valid flags, payload registers keep data.
module eight_bit_alu_with_flags import eba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  operation,
  input  logic [7:0]  accumulator,
  input  logic [7:0]  operand,
  input  logic [3:0]  flags_in,
  input  logic [15:0] word_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_result,
  output logic [15:0] word_result,
  output logic [3:0]  flags_out
);

  logic        s1_valid;
  eba_item_t   s1_item;
  eba_result_t core_result;
  eba_result_t out_result;
  logic        out_free;
  logic        s1_free;

  // Result register takes a new beat when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_valid || out_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item <= '{operation, accumulator, operand, flags_in, word_in};
    end
  end

  eba_core u_core (
    .item   (s1_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_result <= core_result;
    end
  end

  assign byte_result = out_result.byte_result;
  assign word_result = out_result.word_result;
  assign flags_out   = out_result.flags_out;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // A stalled stage-one beat must be held
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_item)))
    else $error("stage-one beat dropped under stall");

  // An empty stage one always takes a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty pipeline");

  // A beat in stage one moves to the output when the output is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> out_valid)
    else $error("stage-one beat lost on advance");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import eba_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  operation = '0;
  logic [7:0]  accumulator = '0;
  logic [7:0]  operand = '0;
  logic [3:0]  flags_in = '0;
  logic [15:0] word_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_result;
  logic [15:0] word_result;
  logic [3:0]  flags_out;

  eight_bit_alu_with_flags uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .accumulator (accumulator),
    .operand     (operand),
    .flags_in    (flags_in),
    .word_in     (word_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_result (byte_result),
    .word_result (word_result),
    .flags_out   (flags_out)
  );

  eba_item_t   pending_ops[$];
  eba_result_t alu_expected[$];
  int unsigned total_ops;
  int unsigned err_count;
  int unsigned cycle_count;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] flag_word(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // {carry out, shifted byte}
  function automatic logic [8:0] shift_byte(logic [2:0] kind, logic [7:0] x, logic cin);
    case (kind)
      SH_RLC:  return {x[7], x[6:0], x[7]};
      SH_RRC:  return {x[0], x[0], x[7:1]};
      SH_RL:   return {x[7], x[6:0], cin};
      SH_RR:   return {x[0], cin, x[7:1]};
      SH_SLA:  return {x[7], x[6:0], 1'b0};
      SH_SRA:  return {x[0], x[7], x[7:1]};
      SH_SWAP: return {1'b0, x[3:0], x[7:4]};
      default: return {x[0], 1'b0, x[7:1]};
    endcase
  endfunction

  function automatic eba_result_t alu_predict(eba_item_t it);
    eba_result_t r;
    logic [7:0]  a;
    logic [7:0]  v;
    logic        fz;
    logic        fn;
    logic        fh;
    logic        fc;
    logic        cy;
    logic [8:0]  wide;
    logic [4:0]  nib;
    logic [7:0]  corr;
    logic [15:0] w;
    a  = it.accumulator;
    v  = it.operand;
    fz = it.flags_in[FLAG_Z];
    fn = it.flags_in[FLAG_N];
    fh = it.flags_in[FLAG_H];
    fc = it.flags_in[FLAG_C];
    r.byte_result = a;
    r.word_result = '0;
    r.flags_out   = it.flags_in;
    case (it.operation)
      OP_ADD, OP_ADC: begin
        cy   = (it.operation == OP_ADC) && fc;
        wide = {1'b0, a} + {1'b0, v} + {8'd0, cy};
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cy};
        r.byte_result = wide[7:0];
        r.flags_out   = flag_word(wide[7:0] == 8'd0, 1'b0, nib[4], wide[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // bit 8 / bit 4 of the widened difference is the borrow
        cy   = (it.operation == OP_SBC) && fc;
        wide = {1'b0, a} - {1'b0, v} - {8'd0, cy};
        nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cy};
        if (it.operation != OP_CP) r.byte_result = wide[7:0];
        r.flags_out = flag_word(wide[7:0] == 8'd0, 1'b1, nib[4], wide[8]);
      end
      OP_AND: begin
        r.byte_result = a & v;
        r.flags_out   = flag_word(r.byte_result == 8'd0, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        r.byte_result = a ^ v;
        r.flags_out   = flag_word(r.byte_result == 8'd0, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        r.byte_result = a | v;
        r.flags_out   = flag_word(r.byte_result == 8'd0, 1'b0, 1'b0, 1'b0);
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        wide = shift_byte(it.operation[2:0], v, fc);
        r.byte_result = wide[7:0];
        r.flags_out   = flag_word(wide[7:0] == 8'd0, 1'b0, 1'b0, wide[8]);
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        wide = shift_byte(it.operation[2:0], a, fc);
        r.byte_result = wide[7:0];
        r.flags_out   = flag_word(1'b0, 1'b0, 1'b0, wide[8]);
      end
      OP_DAA: begin
        corr = '0;
        cy   = fc;
        if (fh || (!fn && a[3:0] > DAA_LO_LIM)) corr = corr | DAA_LO_CORR;
        if (fc || (!fn && a > DAA_HI_LIM)) begin
          corr = corr | DAA_HI_CORR;
          cy   = 1'b1;
        end
        r.byte_result = fn ? a - corr : a + corr;
        r.flags_out   = flag_word(r.byte_result == 8'd0, fn, 1'b0, cy);
      end
      OP_CPL: begin
        r.byte_result = ~a;
        r.flags_out   = flag_word(fz, 1'b1, 1'b1, fc);
      end
      OP_SCF: r.flags_out = flag_word(fz, 1'b0, 1'b0, 1'b1);
      OP_CCF: r.flags_out = flag_word(fz, 1'b0, 1'b0, !fc);
      OP_ADDW: begin
        w    = it.word_in;
        r.word_result = w + {{8{v[7]}}, v};
        nib  = {1'b0, w[3:0]} + {1'b0, v[3:0]};
        wide = {1'b0, w[7:0]} + {1'b0, v};
        r.flags_out   = flag_word(1'b0, 1'b0, nib[4], wide[8]);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(logic [4:0] op, logic [7:0] a, logic [7:0] v, logic [3:0] f,
                          logic [15:0] w);
    eba_item_t it;
    it.operation   = op;
    it.accumulator = a;
    it.operand     = v;
    it.flags_in    = f;
    it.word_in     = w;
    pending_ops.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h99;
      5:       return 8'h9A;
      6:       return 8'h0F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom_range(0, 255)), 8'hFF};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    logic [4:0] op;
    queue_op(OP_ADD,  8'hFF, 8'h01, 4'h0, 16'h0000);
    queue_op(OP_ADC,  8'h0F, 8'h00, 4'h1, 16'h1234);
    queue_op(OP_SUB,  8'h00, 8'h01, 4'h0, 16'h0000);
    queue_op(OP_SBC,  8'h10, 8'h0F, 4'h1, 16'h0000);
    queue_op(OP_CP,   8'h42, 8'h42, 4'h0, 16'h0000);
    queue_op(OP_AND,  8'h0F, 8'hF0, 4'hF, 16'h0000);
    queue_op(OP_XOR,  8'hFF, 8'hFF, 4'h0, 16'h0000);
    queue_op(OP_OR,   8'h00, 8'h00, 4'hF, 16'h0000);
    queue_op(OP_RLC,  8'h00, 8'h80, 4'h0, 16'h0000);
    queue_op(OP_RRC,  8'h00, 8'h01, 4'h0, 16'h0000);
    queue_op(OP_RL,   8'h00, 8'h80, 4'h0, 16'h0000);
    queue_op(OP_RR,   8'h00, 8'h01, 4'h1, 16'h0000);
    queue_op(OP_SLA,  8'h00, 8'h80, 4'h0, 16'h0000);
    queue_op(OP_SRA,  8'h00, 8'h81, 4'h0, 16'h0000);
    queue_op(OP_SWAP, 8'h00, 8'hF0, 4'hF, 16'h0000);
    queue_op(OP_SRL,  8'h00, 8'h01, 4'h0, 16'h0000);
    queue_op(OP_RLCA, 8'h00, 8'h00, 4'hF, 16'h0000);
    queue_op(OP_RRCA, 8'h01, 8'h00, 4'h8, 16'h0000);
    queue_op(OP_RLA,  8'h80, 8'h00, 4'h8, 16'h0000);
    queue_op(OP_RRA,  8'h01, 8'h00, 4'h9, 16'h0000);
    queue_op(OP_DAA,  8'h9A, 8'h00, 4'h0, 16'h0000);
    queue_op(OP_DAA,  8'h00, 8'h00, 4'h7, 16'h0000);
    queue_op(OP_CPL,  8'h5A, 8'h00, 4'h9, 16'h0000);
    queue_op(OP_SCF,  8'h33, 8'h00, 4'h8, 16'h0000);
    queue_op(OP_CCF,  8'h33, 8'h00, 4'h9, 16'h0000);
    queue_op(OP_ADDW, 8'h11, 8'h01, 4'hF, 16'hFFFF);
    queue_op(OP_ADDW, 8'h22, 8'h80, 4'h0, 16'h0000);
    queue_op(5'd31,   8'hA5, 8'hFF, 4'hA, 16'hFFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 19) == 0) op = 5'($urandom_range(25, 31));
      else op = 5'($urandom_range(0, 24));
      queue_op(op, pick_byte(), pick_byte(), 4'($urandom_range(0, 15)), pick_word());
    end
    total_ops = pending_ops.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || alu_expected.size() != 0);
    repeat (10) @(negedge clk);
    if (err_count == 0 && alu_expected.size() == 0)
      $display("** eight_bit_alu_with_flags: PASSED **");
    else
      $display("** eight_bit_alu_with_flags: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, alu_expected.size());
      $display("** eight_bit_alu_with_flags: FAILED **");
      $finish;
    end
  end

  // Sender
  eba_item_t   cur_op;
  int unsigned sent_beats;
  int unsigned send_gap;
  int unsigned send_odds;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      sent_beats = 0;
      send_gap   = 0;
      send_odds  = 2;
    end else begin
      if (in_valid && in_ready) begin
        alu_expected.push_back(alu_predict(cur_op));
        sent_beats++;
        if (sent_beats % 64 == 0) send_odds = $urandom_range(0, 3);
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else if (sent_beats + CALM_TAIL < total_ops && $urandom_range(0, 7) < send_odds)
      begin
        send_gap = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else begin
        cur_op = pending_ops.pop_front();
        in_valid    <= 1'b1;
        operation   <= cur_op.operation;
        accumulator <= cur_op.accumulator;
        operand     <= cur_op.operand;
        flags_in    <= cur_op.flags_in;
        word_in     <= cur_op.word_in;
      end
    end
  end

  // Receiver and checker
  eba_result_t due;
  int unsigned checked_beats;
  int unsigned recv_stall;
  int unsigned recv_odds;
  int unsigned hold_left;
  logic        hold_done;
  logic        ready_next;

  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      checked_beats = 0;
      recv_stall    = 0;
      recv_odds     = 2;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (alu_expected.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected: byte %02h word %04h flags %01h",
                   $time, byte_result, word_result, flags_out);
        end else begin
          due = alu_expected.pop_front();
          if (byte_result !== due.byte_result || word_result !== due.word_result ||
              flags_out !== due.flags_out) begin
            err_count++;
            $display("%0t: mismatch: expected byte %02h word %04h flags %04b,",
                     $time, due.byte_result, due.word_result, due.flags_out,
                     " got byte %02h word %04h flags %04b",
                     byte_result, word_result, flags_out);
          end
        end
        checked_beats++;
        if (checked_beats % 64 == 0) recv_odds = $urandom_range(0, 3);
      end

      // one long back-pressure stretch so the block fills up
      if (!hold_done && checked_beats >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        ready_next = 1'b0;
      end else if (checked_beats + CALM_TAIL < total_ops &&
                   $urandom_range(0, 7) < recv_odds) begin
        recv_stall = $urandom_range(1, 12) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

endmodule
